// ----- sv/lpmr_pkg.sv -----
package lpmr_pkg;

  // default sizes
  localparam int unsigned BufBytesDef = 4096;
  localparam int unsigned HdrBytesDef = 8;

  // capacity register after reset
  localparam logic [12:0] CapReset = 13'd4096;

  typedef enum logic [1:0] {
    OP_PUT_HDR  = 2'd0,
    OP_PUT_BYTE = 2'd1,
    OP_GET      = 2'd2,
    OP_DRAIN    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_TOO_SMALL = 3'd3,
    ST_PROTO     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_DRAIN = 2'd1,
    KIND_GET   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_DRAIN,
    S_CHECK,
    S_RD,
    S_CAP,
    S_EVAL,
    S_FIN
  } state_e;

  typedef struct packed {
    logic    accept;
    logic    hdr_start;
    logic    hdr_next;
    logic    put_byte;
    logic    walk_init;
    logic    walk_hdr;
    logic    walk_rd;
    logic    walk_cap;
    logic    walk_eval;
    logic    walk_take;
    logic    drain_pop;
    logic    out_load;
    status_e out_status;
    kind_e   out_kind;
  } cmd_t;

  typedef struct packed {
    logic put_err;
    logic put_full;
    logic put_open;
    logic hdr_single;
    logic hdr_last;
    logic drain_busy;
    logic used_zero;
    logic walk_go;
    logic avail_zero;
    logic byte_last;
    logic too_small;
    logic too_short;
  } sts_t;

endpackage

// ----- sv/lpmr_ram.sv -----
module lpmr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/lpmr_ctrl.sv -----
module lpmr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  lpmr_pkg::sts_t       sts_i,
  output lpmr_pkg::cmd_t       cmd_o
);

  lpmr_pkg::state_e state_q, state_d;
  lpmr_pkg::status_e fin_q, fin_d;
  logic out_valid_q;
  logic take;
  lpmr_pkg::cmd_t cmd;

  // take a word only when idle and the result slot frees up
  assign in_stall_o = !((state_q == lpmr_pkg::S_IDLE) && (!out_valid_q || !out_stall_i));
  assign take = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpmr_pkg::S_IDLE;
      fin_q       <= lpmr_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    cmd     = '0;
    cmd.out_status = lpmr_pkg::ST_OK;
    cmd.out_kind   = lpmr_pkg::KIND_PLAIN;
    unique case (state_q)
      lpmr_pkg::S_IDLE: begin
        if (take) begin
          cmd.accept = 1'b1;
          unique case (lpmr_pkg::op_e'(op_i))
            lpmr_pkg::OP_PUT_HDR: begin
              if (sts_i.put_err) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = lpmr_pkg::ST_PROTO;
              end else if (sts_i.put_full) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = lpmr_pkg::ST_FULL;
              end else begin
                cmd.hdr_start = 1'b1;
                if (sts_i.hdr_single) begin
                  cmd.out_load = 1'b1;
                end else begin
                  state_d = lpmr_pkg::S_HDR;
                end
              end
            end
            lpmr_pkg::OP_PUT_BYTE: begin
              cmd.out_load = 1'b1;
              if (!sts_i.put_open) begin
                cmd.out_status = lpmr_pkg::ST_PROTO;
              end else begin
                cmd.put_byte = 1'b1;
              end
            end
            lpmr_pkg::OP_GET: begin
              if (sts_i.put_open || sts_i.drain_busy) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = lpmr_pkg::ST_PROTO;
              end else if (sts_i.used_zero) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = lpmr_pkg::ST_EMPTY;
              end else begin
                cmd.walk_init = 1'b1;
                state_d = lpmr_pkg::S_CHECK;
              end
            end
            lpmr_pkg::OP_DRAIN: begin
              if (!sts_i.drain_busy) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = lpmr_pkg::ST_PROTO;
              end else begin
                cmd.drain_pop = 1'b1;
                state_d = lpmr_pkg::S_DRAIN;
              end
            end
            default: ;
          endcase
        end
      end
      lpmr_pkg::S_HDR: begin
        cmd.hdr_next = 1'b1;
        if (sts_i.hdr_last) begin
          cmd.out_load = 1'b1;
          state_d = lpmr_pkg::S_IDLE;
        end
      end
      lpmr_pkg::S_DRAIN: begin
        cmd.out_load = 1'b1;
        cmd.out_kind = lpmr_pkg::KIND_DRAIN;
        state_d = lpmr_pkg::S_IDLE;
      end
      lpmr_pkg::S_CHECK: begin
        if (sts_i.walk_go && !sts_i.avail_zero) begin
          cmd.walk_hdr = 1'b1;
          state_d = lpmr_pkg::S_RD;
        end else begin
          cmd.out_load = 1'b1;
          cmd.out_kind = lpmr_pkg::KIND_GET;
          state_d = lpmr_pkg::S_IDLE;
        end
      end
      lpmr_pkg::S_RD: begin
        cmd.walk_rd = 1'b1;
        state_d = lpmr_pkg::S_CAP;
      end
      lpmr_pkg::S_CAP: begin
        cmd.walk_cap = 1'b1;
        state_d = sts_i.byte_last ? lpmr_pkg::S_EVAL : lpmr_pkg::S_RD;
      end
      lpmr_pkg::S_EVAL: begin
        cmd.walk_eval = 1'b1;
        if (sts_i.too_small) begin
          fin_d   = lpmr_pkg::ST_TOO_SMALL;
          state_d = lpmr_pkg::S_FIN;
        end else if (sts_i.too_short) begin
          fin_d   = lpmr_pkg::ST_OK;
          state_d = lpmr_pkg::S_FIN;
        end else begin
          cmd.walk_take = 1'b1;
          state_d = lpmr_pkg::S_CHECK;
        end
      end
      lpmr_pkg::S_FIN: begin
        cmd.out_load   = 1'b1;
        cmd.out_kind   = lpmr_pkg::KIND_GET;
        cmd.out_status = fin_q;
        state_d = lpmr_pkg::S_IDLE;
      end
      default: state_d = lpmr_pkg::S_IDLE;
    endcase
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/lpmr_dp.sv -----
module lpmr_dp #(
  parameter int unsigned BUF_BYTES = lpmr_pkg::BufBytesDef,
  parameter int unsigned HDR_BYTES = lpmr_pkg::HdrBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [12:0]    cfg_wdata_i,
  input  logic [12:0]    msg_len_i,
  input  logic [7:0]     data_byte_i,
  input  logic [12:0]    max_messages_i,
  input  logic [12:0]    max_bytes_i,
  input  logic [15:0]    out_capacity_i,
  input  lpmr_pkg::cmd_t cmd_i,
  output lpmr_pkg::sts_t sts_o,
  output logic [2:0]     status_o,
  output logic [7:0]     out_byte_o,
  output logic           last_o,
  output logic [9:0]     msg_count_o,
  output logic [12:0]    byte_count_o,
  output logic [13:0]    needed_bytes_o
);

  localparam int unsigned PtrW  = $clog2(BUF_BYTES);
  localparam int unsigned CntW  = $clog2(BUF_BYTES + 1);
  localparam int unsigned WW    = ((CntW > 16) ? CntW : 16) + 1;
  localparam int unsigned HidxW = (HDR_BYTES > 1) ? $clog2(HDR_BYTES) : 1;
  localparam int unsigned NumLenBytes = (HDR_BYTES > 1) ? 2 : 1;

  // ring state
  logic [12:0]     cap_q;
  logic [PtrW-1:0] rptr_q, wptr_q;
  logic [CntW-1:0] used_q, drain_q;
  logic            open_q;
  logic [12:0]     put_rem_q;
  logic [HidxW-1:0] hidx_q;

  // item fields and walk state
  logic [12:0]     len_q, maxm_q, maxb_q, msgs_q;
  logic [15:0]     room_q, mlen_q;
  logic [PtrW-1:0] p_q, a_q;
  logic [CntW-1:0] avail_q;
  logic [WW-1:0]   bytes_q, need_q;
  logic            k_q;

  // result word
  lpmr_pkg::status_e st_q;
  logic [7:0]  obyte_q;
  logic        last_q;
  logic [9:0]  mcnt_q;
  logic [12:0] bcnt_q;
  logic [13:0] need_out_q;

  logic [WW-1:0]   cap_w, eff_cap, w_inc, r_inc, a_inc, total, need_n, p_sum;
  logic [PtrW-1:0] wptr_nx, rptr_nx, a_nx, p_nx;
  logic            len_bad, ram_we;
  logic [PtrW-1:0] ram_addr;
  logic [7:0]      ram_wdata, ram_rdata, hdr_byte;
  logic [15:0]     len16;

  // effective capacity, clamped to 1..BUF_BYTES
  assign cap_w   = WW'(cap_q);
  assign eff_cap = (cap_q == '0) ? WW'(1) :
                   ((cap_w > WW'(BUF_BYTES)) ? WW'(BUF_BYTES) : cap_w);

  // pointer steps with wrap
  assign w_inc   = WW'(wptr_q) + WW'(1);
  assign wptr_nx = (w_inc == eff_cap) ? '0 : w_inc[PtrW-1:0];
  assign r_inc   = WW'(rptr_q) + WW'(1);
  assign rptr_nx = (r_inc == eff_cap) ? '0 : r_inc[PtrW-1:0];
  assign a_inc   = WW'(a_q) + WW'(1);
  assign a_nx    = (a_inc == eff_cap) ? '0 : a_inc[PtrW-1:0];

  // walk arithmetic
  assign total  = WW'(HDR_BYTES) + WW'(mlen_q);
  assign need_n = need_q + total;
  assign p_sum  = WW'(p_q) + total;
  assign p_nx   = (p_sum >= eff_cap) ? PtrW'(p_sum - eff_cap) : p_sum[PtrW-1:0];

  // header byte being written
  assign len16 = {3'b000, len_q};
  always_comb begin
    if (hidx_q == HidxW'(0)) begin
      hdr_byte = len16[7:0];
    end else if (hidx_q == HidxW'(1)) begin
      hdr_byte = len16[15:8];
    end else begin
      hdr_byte = 8'd0;
    end
  end

  assign len_bad = (HDR_BYTES == 1) && (msg_len_i[12:8] != 5'd0);

  // memory port
  assign ram_we    = cmd_i.put_byte | cmd_i.hdr_start | cmd_i.hdr_next;
  assign ram_addr  = ram_we ? wptr_q : (cmd_i.walk_rd ? a_q : rptr_q);
  assign ram_wdata = cmd_i.put_byte ? data_byte_i :
                     (cmd_i.hdr_start ? msg_len_i[7:0] : hdr_byte);

  lpmr_ram #(
    .Width (8),
    .Depth (BUF_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // status to the controller
  always_comb begin
    sts_o.put_err    = open_q || len_bad;
    sts_o.put_full   = (WW'(used_q) + WW'(HDR_BYTES) + WW'(msg_len_i)) > eff_cap;
    sts_o.put_open   = open_q;
    sts_o.hdr_single = (HDR_BYTES == 1);
    sts_o.hdr_last   = (hidx_q == HidxW'(HDR_BYTES - 1));
    sts_o.drain_busy = (drain_q != '0);
    sts_o.used_zero  = (used_q == '0);
    sts_o.walk_go    = (msgs_q < maxm_q) && (bytes_q < WW'(maxb_q));
    sts_o.avail_zero = (avail_q == '0);
    sts_o.byte_last  = (k_q == 1'(NumLenBytes - 1));
    sts_o.too_small  = WW'(room_q) < need_n;
    sts_o.too_short  = WW'(avail_q) < total;
  end

  // ring control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= lpmr_pkg::CapReset;
      rptr_q    <= '0;
      wptr_q    <= '0;
      used_q    <= '0;
      drain_q   <= '0;
      open_q    <= 1'b0;
      put_rem_q <= '0;
      hidx_q    <= '0;
    end else if (cfg_we_i) begin
      cap_q     <= cfg_wdata_i;
      rptr_q    <= '0;
      wptr_q    <= '0;
      used_q    <= '0;
      drain_q   <= '0;
      open_q    <= 1'b0;
      put_rem_q <= '0;
    end else begin
      if (ram_we) begin
        wptr_q <= wptr_nx;
        used_q <= used_q + CntW'(1);
      end
      if (cmd_i.hdr_start) begin
        put_rem_q <= msg_len_i;
        open_q    <= (msg_len_i != '0);
        hidx_q    <= HidxW'(1);
      end
      if (cmd_i.hdr_next) begin
        hidx_q <= hidx_q + HidxW'(1);
      end
      if (cmd_i.put_byte) begin
        put_rem_q <= put_rem_q - 13'd1;
        if (put_rem_q == 13'd1) begin
          open_q <= 1'b0;
        end
      end
      if (cmd_i.drain_pop) begin
        rptr_q  <= rptr_nx;
        drain_q <= drain_q - CntW'(1);
        if (used_q != '0) begin
          used_q <= used_q - CntW'(1);
        end
      end
      if (cmd_i.out_load && (cmd_i.out_kind == lpmr_pkg::KIND_GET)) begin
        drain_q <= bytes_q[CntW-1:0];
      end
    end
  end

  // item fields and batch walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      len_q  <= msg_len_i;
      maxm_q <= max_messages_i;
      maxb_q <= max_bytes_i;
      room_q <= out_capacity_i;
    end
    if (cmd_i.walk_init) begin
      p_q     <= rptr_q;
      avail_q <= used_q;
      msgs_q  <= '0;
      bytes_q <= '0;
      need_q  <= '0;
    end
    if (cmd_i.walk_hdr) begin
      a_q    <= p_q;
      k_q    <= 1'b0;
      mlen_q <= '0;
    end
    if (cmd_i.walk_cap) begin
      if (k_q == 1'b0) begin
        mlen_q[7:0] <= ram_rdata;
      end else begin
        mlen_q[15:8] <= ram_rdata;
      end
      a_q <= a_nx;
      k_q <= ~k_q;
    end
    if (cmd_i.walk_eval) begin
      need_q <= need_n;
    end
    if (cmd_i.walk_take) begin
      p_q     <= p_nx;
      bytes_q <= bytes_q + total;
      msgs_q  <= msgs_q + 13'd1;
      avail_q <= CntW'(WW'(avail_q) - total);
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      st_q       <= cmd_i.out_status;
      obyte_q    <= 8'd0;
      last_q     <= 1'b0;
      mcnt_q     <= '0;
      bcnt_q     <= '0;
      need_out_q <= '0;
      unique case (cmd_i.out_kind)
        lpmr_pkg::KIND_DRAIN: begin
          obyte_q <= ram_rdata;
          last_q  <= (drain_q == '0);
        end
        lpmr_pkg::KIND_GET: begin
          mcnt_q     <= (msgs_q > 13'd1023) ? 10'd1023 : msgs_q[9:0];
          bcnt_q     <= bytes_q[12:0];
          need_out_q <= need_q[13:0];
        end
        default: ;
      endcase
    end
  end

  assign status_o       = st_q;
  assign out_byte_o     = obyte_q;
  assign last_o         = last_q;
  assign msg_count_o    = mcnt_q;
  assign byte_count_o   = bcnt_q;
  assign needed_bytes_o = need_out_q;

endmodule

// ----- sv/length_prefixed_message_ring_top.sv -----
// Byte ring queue of length-prefixed messages.
// Input channel (in_valid_i / in_stall_o) takes one word per operation:
// put header, put payload byte, get start (plan a batch), drain one byte.
// Output channel (out_valid_o / out_stall_i) returns exactly one result word
// per input word, in order, from an output register.
// Steps per word, accept to result register: put byte and any rejected word
// load the result on accept; drain pops a byte on accept and loads it in
// S_DRAIN; put header writes HDR_BYTES header bytes, one header byte per cycle
// through the single ring memory port; get start walks the stored messages,
// reading L length bytes of each, where L is 2 (1 if HDR_BYTES is 1). The ring
// memory has a single port; one word is worked on at a time and the next is
// taken once the result register is free or being taken in the same cycle.
// Reset (rst_ni low) empties the queue and sets capacity to 4096 bytes; no
// clearing pass is needed. A write on cfg_we_i sets the capacity and empties
// the queue; write it only while idle.
// While the receiver stalls, the result word holds and in_stall_o stays high.
module length_prefixed_message_ring_top #(
  parameter int unsigned BUF_BYTES = lpmr_pkg::BufBytesDef,
  parameter int unsigned HDR_BYTES = lpmr_pkg::HdrBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [12:0] msg_len_i,
  input  logic [7:0]  data_byte_i,
  input  logic [12:0] max_messages_i,
  input  logic [12:0] max_bytes_i,
  input  logic [15:0] out_capacity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [9:0]  msg_count_o,
  output logic [12:0] byte_count_o,
  output logic [13:0] needed_bytes_o
);

  lpmr_pkg::cmd_t cmd;
  lpmr_pkg::sts_t sts;

  // sequencer
  lpmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // ring memory, pointers and result word
  lpmr_dp #(
    .BUF_BYTES (BUF_BYTES),
    .HDR_BYTES (HDR_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .msg_len_i      (msg_len_i),
    .data_byte_i    (data_byte_i),
    .max_messages_i (max_messages_i),
    .max_bytes_i    (max_bytes_i),
    .out_capacity_i (out_capacity_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o),
    .msg_count_o    (msg_count_o),
    .byte_count_o   (byte_count_o),
    .needed_bytes_o (needed_bytes_o)
  );

endmodule
